### hdl/bcsld_pkg.sv
`default_nettype none

package bcsld_pkg;

    localparam int LEVEL_W    = 8;
    localparam int SHIFT_W    = 4;
    localparam int DUTY_W     = 9;
    localparam int COLOR_W    = 5;
    localparam int DEBOUNCE_W = 4;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int SHIFT_MAX  = 15;
    localparam int PROD_W     = LEVEL_W + SHIFT_MAX;
    localparam int ROM_SIZE   = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 4'd15;
    localparam logic [HOLD_W-1:0]     LONG_PRESS_RESET = 16'd2000;

    typedef struct packed {
        logic [SHIFT_W-1:0] red;
        logic [SHIFT_W-1:0] green;
        logic [SHIFT_W-1:0] blue;
    } shift_set_t;

    typedef struct packed {
        shift_set_t         shifts;
        logic [COLOR_W-1:0] color;
        logic               blanked;
    } ctrl_view_t;

    typedef struct packed {
        logic [DUTY_W-1:0] red_a;
        logic [DUTY_W-1:0] green_a;
        logic [DUTY_W-1:0] blue_a;
        logic [DUTY_W-1:0] red_b;
        logic [DUTY_W-1:0] green_b;
        logic [DUTY_W-1:0] blue_b;
    } duty_set_t;

    localparam shift_set_t WHITE_ENTRY = '{4'd8, 4'd8, 4'd8};

    localparam shift_set_t COLOR_ROM [ROM_SIZE] = '{
        '{4'd8, 4'd8, 4'd8}, '{4'd8, 4'd0, 4'd0}, '{4'd8, 4'd6, 4'd0},
        '{4'd8, 4'd7, 4'd0}, '{4'd8, 4'd8, 4'd0}, '{4'd7, 4'd8, 4'd0},
        '{4'd6, 4'd8, 4'd0}, '{4'd0, 4'd8, 4'd0}, '{4'd0, 4'd8, 4'd6},
        '{4'd0, 4'd8, 4'd7}, '{4'd0, 4'd8, 4'd8}, '{4'd0, 4'd7, 4'd8},
        '{4'd0, 4'd5, 4'd8}, '{4'd0, 4'd0, 4'd8}, '{4'd6, 4'd0, 4'd8},
        '{4'd8, 4'd0, 4'd8}, '{4'd8, 4'd0, 4'd6}
    };

    // Entries past the end of the table read as white.
    function automatic shift_set_t color_entry(input logic [COLOR_W-1:0] idx);
        shift_set_t entry;
        if (idx < COLOR_W'(ROM_SIZE))
        begin
            entry = COLOR_ROM[idx];
        end
        else
        begin
            entry = WHITE_ENTRY;
        end
        return entry;
    endfunction

endpackage

`default_nettype wire

### hdl/bcsld_tick_if.sv
`default_nettype none

interface bcsld_tick_if;
    logic                          valid;
    logic                          ready;
    logic                          button_arm;
    logic                          button_pin;
    logic                          led_signal;
    logic [bcsld_pkg::LEVEL_W-1:0] source_level;

    modport source (
        output valid, button_arm, button_pin, led_signal, source_level,
        input  ready
    );

    modport sink (
        input  valid, button_arm, button_pin, led_signal, source_level,
        output ready
    );
endinterface

`default_nettype wire

### hdl/bcsld_result_if.sv
`default_nettype none

interface bcsld_result_if;
    logic                          valid;
    logic                          ready;
    logic [bcsld_pkg::DUTY_W-1:0]  duty_red_a;
    logic [bcsld_pkg::DUTY_W-1:0]  duty_green_a;
    logic [bcsld_pkg::DUTY_W-1:0]  duty_blue_a;
    logic [bcsld_pkg::DUTY_W-1:0]  duty_red_b;
    logic [bcsld_pkg::DUTY_W-1:0]  duty_green_b;
    logic [bcsld_pkg::DUTY_W-1:0]  duty_blue_b;
    logic [bcsld_pkg::COLOR_W-1:0] current_color;
    logic                          lights_blanked;

    modport source (
        output valid, duty_red_a, duty_green_a, duty_blue_a,
               duty_red_b, duty_green_b, duty_blue_b, current_color, lights_blanked,
        input  ready
    );

    modport sink (
        input  valid, duty_red_a, duty_green_a, duty_blue_a,
               duty_red_b, duty_green_b, duty_blue_b, current_color, lights_blanked,
        output ready
    );
endinterface

`default_nettype wire

### hdl/bcsld_ctrl.sv
`default_nettype none

module bcsld_ctrl #(
    parameter int NUM_COLORS = 17
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bcsld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bcsld_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                step,
    input  wire logic                                arm,
    input  wire logic                                pin_high,
    output bcsld_pkg::ctrl_view_t                    view
);

    localparam int CW = bcsld_pkg::COLOR_W;
    localparam logic [CW:0] NUM_COLORS_L = (CW+1)'(NUM_COLORS);

    logic [bcsld_pkg::DEBOUNCE_W-1:0] debounce_limit_reg;
    logic [bcsld_pkg::HOLD_W-1:0]     long_press_reg;

    logic                             idle_wait_reg,   idle_wait_next;
    logic                             press_seen_reg,  press_seen_next;
    logic [bcsld_pkg::DEBOUNCE_W-1:0] agree_count_reg, agree_count_next;
    logic [bcsld_pkg::HOLD_W-1:0]     hold_count_reg,  hold_count_next;
    logic [CW-1:0]                    color_index_reg, color_index_next;
    logic [CW-1:0]                    saved_index_reg, saved_index_next;
    bcsld_pkg::shift_set_t            shift_reg,       shift_next;

    logic                             was_pressed;
    logic [CW:0]                      color_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg <= bcsld_pkg::DEBOUNCE_RESET;
            long_press_reg     <= bcsld_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bcsld_pkg::REG_DEBOUNCE_LIMIT:
                    debounce_limit_reg <= cfg_data[bcsld_pkg::DEBOUNCE_W-1:0];
                bcsld_pkg::REG_LONG_PRESS_TICKS:
                    long_press_reg <= cfg_data[bcsld_pkg::HOLD_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        idle_wait_next   = idle_wait_reg;
        press_seen_next  = press_seen_reg;
        agree_count_next = agree_count_reg;
        hold_count_next  = hold_count_reg;
        color_index_next = color_index_reg;
        saved_index_next = saved_index_reg;
        shift_next       = shift_reg;
        was_pressed      = 1'b0;
        color_inc        = {1'b0, color_index_reg} + (CW+1)'(1);

        // Arm from idle: restart the debounce, keep the hold count
        if (arm && idle_wait_reg)
        begin
            idle_wait_next   = 1'b0;
            press_seen_next  = 1'b0;
            agree_count_next = '0;
        end

        if (!idle_wait_next)
        begin
            was_pressed = press_seen_next;
            if (pin_high == was_pressed)
            begin
                agree_count_next = agree_count_next + 1'b1;
            end
            if (was_pressed && (hold_count_next < long_press_reg))
            begin
                hold_count_next = hold_count_next + 1'b1;
                if (hold_count_next == long_press_reg)
                begin
                    saved_index_next = color_index_reg;
                    shift_next       = '0;
                end
            end
            if (agree_count_next == debounce_limit_reg)
            begin
                agree_count_next = '0;
                if (!was_pressed)
                begin
                    press_seen_next = 1'b1;
                    hold_count_next = '0;
                end
                else
                begin
                    press_seen_next = 1'b0;
                    idle_wait_next  = 1'b1;
                    if (hold_count_next == long_press_reg)
                    begin
                        // Long release: restore the saved colour
                        hold_count_next = '0;
                        if ({1'b0, saved_index_next} < NUM_COLORS_L)
                        begin
                            color_index_next = saved_index_next;
                        end
                        else
                        begin
                            color_index_next = '0;
                        end
                    end
                    else if (color_inc == NUM_COLORS_L)
                    begin
                        color_index_next = '0;
                    end
                    else
                    begin
                        color_index_next = color_inc[CW-1:0];
                    end
                    shift_next = bcsld_pkg::color_entry(color_index_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_wait_reg   <= 1'b1;
            press_seen_reg  <= 1'b0;
            agree_count_reg <= '0;
            hold_count_reg  <= '0;
            color_index_reg <= '0;
            saved_index_reg <= '0;
            shift_reg       <= bcsld_pkg::WHITE_ENTRY;
        end
        else if (step)
        begin
            idle_wait_reg   <= idle_wait_next;
            press_seen_reg  <= press_seen_next;
            agree_count_reg <= agree_count_next;
            hold_count_reg  <= hold_count_next;
            color_index_reg <= color_index_next;
            saved_index_reg <= saved_index_next;
            shift_reg       <= shift_next;
        end
    end

    assign view.shifts  = shift_next;
    assign view.color   = color_index_next;
    assign view.blanked = (shift_next == '0);

`ifndef SYNTHESIS
    a_idle_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        idle_wait_reg |-> !press_seen_reg)
        else $error("press seen while waiting for arm");

    a_color_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, color_index_reg} < NUM_COLORS_L)
        else $error("colour index out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(color_index_reg) && $stable(hold_count_reg))
        else $error("state moved without a tick");
`endif

endmodule

`default_nettype wire

### hdl/bcsld_duty.sv
`default_nettype none

module bcsld_duty #(
    parameter int LEVEL_MAX  = 127,
    parameter int EXTRA_BITS = 2
) (
    input  wire logic [bcsld_pkg::LEVEL_W-1:0] source_level,
    input  wire logic                          led_signal,
    input  wire bcsld_pkg::shift_set_t         shifts,
    output bcsld_pkg::duty_set_t               duties
);

    localparam int LW   = bcsld_pkg::LEVEL_W;
    localparam int DROP = LW - EXTRA_BITS;
    localparam logic [LW-1:0] LEVEL_MAX_L = LW'(LEVEL_MAX);

    logic [LW-1:0] level_clamped;
    logic [LW-1:0] p_a;
    logic [LW-1:0] p_b;

    function automatic logic [bcsld_pkg::DUTY_W-1:0] duty_of(
        input logic [LW-1:0]                 p,
        input logic [bcsld_pkg::SHIFT_W-1:0] sh
    );
        logic [bcsld_pkg::PROD_W-1:0] v;
        v = ({{bcsld_pkg::SHIFT_MAX{1'b0}}, p} << sh) >> DROP;
        return v[bcsld_pkg::DUTY_W-1:0];
    endfunction

    always_comb
    begin
        level_clamped = (source_level > LEVEL_MAX_L) ? LEVEL_MAX_L : source_level;
        p_a           = LEVEL_MAX_L - level_clamped;
        p_b           = led_signal ? '0 : LEVEL_MAX_L;

        duties.red_a   = duty_of(p_a, shifts.red);
        duties.green_a = duty_of(p_a, shifts.green);
        duties.blue_a  = duty_of(p_a, shifts.blue);
        duties.red_b   = duty_of(p_b, shifts.red);
        duties.green_b = duty_of(p_b, shifts.green);
        duties.blue_b  = duty_of(p_b, shifts.blue);
    end

endmodule

`default_nettype wire

### hdl/button_color_selector_led_duty.sv
`default_nettype none

// Channel   Dir  Fields
// tick      in   button_arm, button_pin, led_signal, source_level
// result    out  duty_{red,green,blue}_{a,b}, current_color, lights_blanked
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// One tick per clock unless the result stalls; a taken tick passes from the
// input register through the button state update and duty logic into the
// result register, where its result beat stays valid until it is accepted.
// Reset clears both valid flags and the button state and sets the registers
// (debounce 15, long press 2000). A stalled result holds the input register;
// tick.ready stays high while the input register is empty or the result drains.

module button_color_selector_led_duty #(
    parameter int NUM_COLORS = 17,
    parameter int LEVEL_MAX  = 127,
    parameter int EXTRA_BITS = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bcsld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bcsld_pkg::CFG_DATA_W-1:0] cfg_data,
    bcsld_tick_if.sink                            tick,
    bcsld_result_if.source                        result
);

    logic                          in_valid_reg;
    logic                          arm_reg;
    logic                          pin_reg;
    logic                          led_reg;
    logic [bcsld_pkg::LEVEL_W-1:0] level_reg;

    logic                          result_valid_reg;
    bcsld_pkg::duty_set_t          duty_reg;
    logic [bcsld_pkg::COLOR_W-1:0] color_reg;
    logic                          blanked_reg;

    logic                          advance;
    logic                          step;
    bcsld_pkg::ctrl_view_t         view;
    bcsld_pkg::duty_set_t          duty_next;

    assign advance    = !result_valid_reg || result.ready;
    assign step       = in_valid_reg && advance;
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            arm_reg   <= tick.button_arm;
            pin_reg   <= tick.button_pin;
            led_reg   <= tick.led_signal;
            level_reg <= tick.source_level;
        end
    end

    bcsld_ctrl #(
        .NUM_COLORS (NUM_COLORS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .arm       (arm_reg),
        .pin_high  (pin_reg),
        .view      (view)
    );

    bcsld_duty #(
        .LEVEL_MAX  (LEVEL_MAX),
        .EXTRA_BITS (EXTRA_BITS)
    ) u_duty (
        .source_level (level_reg),
        .led_signal   (led_reg),
        .shifts       (view.shifts),
        .duties       (duty_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= in_valid_reg;
        end
    end

    // Load the result beat only when a tick moves out of the input register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            duty_reg    <= duty_next;
            color_reg   <= view.color;
            blanked_reg <= view.blanked;
        end
    end

    assign result.valid          = result_valid_reg;
    assign result.duty_red_a     = duty_reg.red_a;
    assign result.duty_green_a   = duty_reg.green_a;
    assign result.duty_blue_a    = duty_reg.blue_a;
    assign result.duty_red_b     = duty_reg.red_b;
    assign result.duty_green_b   = duty_reg.green_b;
    assign result.duty_blue_b    = duty_reg.blue_b;
    assign result.current_color  = color_reg;
    assign result.lights_blanked = blanked_reg;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> tick.ready)
        else $error("input stalled with empty result register");

    a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> result_valid_reg)
        else $error("tick lost between stages");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int COLOR_COUNT     = 17;
    localparam int LEVEL_CAP       = 127;
    localparam int EXTRA           = 2;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct packed {
        logic                          arm;
        logic                          pin;
        logic                          led;
        logic [bcsld_pkg::LEVEL_W-1:0] level;
    } tick_t;

    typedef struct packed {
        bcsld_pkg::duty_set_t          duty;
        logic [bcsld_pkg::COLOR_W-1:0] color;
        logic                          blanked;
    } lamp_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [bcsld_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bcsld_pkg::CFG_DATA_W-1:0] cfg_data;

    bcsld_tick_if   tick_ch ();
    bcsld_result_if result_ch ();

    button_color_selector_led_duty dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    // Button state and register copies of the selector
    logic                             sel_idle;
    logic                             sel_pressed;
    logic [bcsld_pkg::DEBOUNCE_W-1:0] sel_agree;
    logic [bcsld_pkg::HOLD_W-1:0]     sel_hold;
    logic [bcsld_pkg::COLOR_W-1:0]    sel_color;
    logic [bcsld_pkg::COLOR_W-1:0]    sel_saved;
    bcsld_pkg::shift_set_t            sel_shifts;
    logic [bcsld_pkg::DEBOUNCE_W-1:0] db_limit;
    logic [bcsld_pkg::HOLD_W-1:0]     lp_limit;

    lamp_result_t lamp_results_due[$];
    int           fail_count;
    int           cycle_count;
    int           random_sent;
    int           hold_off_requests;
    int           hold_off_served;
    bit           src_quiet;
    bit           sink_quiet;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return 0;
        else if (r < 93)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(8, 30));
    endfunction

    function automatic bcsld_pkg::shift_set_t entry_for(
        input logic [bcsld_pkg::COLOR_W-1:0] idx
    );
        return (idx < bcsld_pkg::ROM_SIZE) ? bcsld_pkg::COLOR_ROM[idx]
                                           : bcsld_pkg::WHITE_ENTRY;
    endfunction

    function automatic logic [bcsld_pkg::DUTY_W-1:0] duty_for(
        input logic [7:0]                    p,
        input logic [bcsld_pkg::SHIFT_W-1:0] sh
    );
        logic [31:0] v;
        v = ({24'd0, p} << sh) >> (8 - EXTRA);
        return v[bcsld_pkg::DUTY_W-1:0];
    endfunction

    function automatic void reset_selector();
        sel_idle    = 1'b1;
        sel_pressed = 1'b0;
        sel_agree   = '0;
        sel_hold    = '0;
        sel_color   = '0;
        sel_saved   = '0;
        sel_shifts  = entry_for('0);
        db_limit    = bcsld_pkg::DEBOUNCE_RESET;
        lp_limit    = bcsld_pkg::LONG_PRESS_RESET;
    endfunction

    function automatic lamp_result_t advance_selector(input tick_t t);
        lamp_result_t r;
        logic         was_pressed;
        logic [7:0]   lvl;
        logic [7:0]   p_a;
        logic [7:0]   p_b;
        if (t.arm && sel_idle)
        begin
            sel_idle    = 1'b0;
            sel_pressed = 1'b0;
            sel_agree   = '0;
        end
        if (!sel_idle)
        begin
            was_pressed = sel_pressed;
            // pin low agrees with a pending press, pin high with a pending release
            if (t.pin == was_pressed)
                sel_agree = sel_agree + 1'b1;
            if (was_pressed && sel_hold < lp_limit)
            begin
                sel_hold = sel_hold + 1'b1;
                if (sel_hold == lp_limit)
                begin
                    sel_saved  = sel_color;
                    sel_shifts = '0;
                end
            end
            if (sel_agree == db_limit)
            begin
                sel_agree = '0;
                if (!was_pressed)
                begin
                    sel_pressed = 1'b1;
                    sel_hold    = '0;
                end
                else
                begin
                    sel_pressed = 1'b0;
                    sel_idle    = 1'b1;
                    if (sel_hold == lp_limit)
                    begin
                        sel_hold  = '0;
                        sel_color = (sel_saved < COLOR_COUNT) ? sel_saved : '0;
                    end
                    else
                    begin
                        sel_color = bcsld_pkg::COLOR_W'((sel_color + 1) % COLOR_COUNT);
                    end
                    sel_shifts = entry_for(sel_color);
                end
            end
        end
        lvl = (t.level > LEVEL_CAP) ? 8'(LEVEL_CAP) : t.level;
        p_a = 8'(LEVEL_CAP) - lvl;
        p_b = t.led ? 8'd0 : 8'(LEVEL_CAP);
        r.duty.red_a   = duty_for(p_a, sel_shifts.red);
        r.duty.green_a = duty_for(p_a, sel_shifts.green);
        r.duty.blue_a  = duty_for(p_a, sel_shifts.blue);
        r.duty.red_b   = duty_for(p_b, sel_shifts.red);
        r.duty.green_b = duty_for(p_b, sel_shifts.green);
        r.duty.blue_b  = duty_for(p_b, sel_shifts.blue);
        r.color        = sel_color;
        r.blanked      = (sel_shifts == '0);
        return r;
    endfunction

    task automatic send_tick(input tick_t t);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.button_arm   <= t.arm;
        tick_ch.button_pin   <= t.pin;
        tick_ch.led_signal   <= t.led;
        tick_ch.source_level <= t.level;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        lamp_results_due.push_back(advance_selector(t));
    endtask

    task automatic offer(input logic arm, input logic pin);
        tick_t t;
        int    r;
        t.arm = arm;
        t.pin = pin;
        t.led = 1'($urandom_range(0, 1));
        r = int'($urandom_range(0, 9));
        case (r)
            0:       t.level = 8'd0;
            1:       t.level = 8'd127;
            2:       t.level = 8'd128;
            3:       t.level = 8'd255;
            default: t.level = 8'($urandom_range(0, 255));
        endcase
        send_tick(t);
        random_sent++;
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (lamp_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Call only with nothing in flight.
    task automatic set_controls(input logic [bcsld_pkg::DEBOUNCE_W-1:0] db,
                                input logic [bcsld_pkg::HOLD_W-1:0]     lp);
        cfg_we    <= 1'b1;
        cfg_index <= bcsld_pkg::REG_DEBOUNCE_LIMIT;
        cfg_data  <= {12'($urandom_range(0, 4095)), db};
        @(posedge clk);
        cfg_index <= bcsld_pkg::REG_LONG_PRESS_TICKS;
        cfg_data  <= lp;
        @(posedge clk);
        cfg_we   <= 1'b0;
        db_limit = db;
        lp_limit = lp;
    endtask

    task automatic test_reset_outputs();
        send_tick('{1'b0, 1'b1, 1'b0, 8'd0});
        send_tick('{1'b0, 1'b1, 1'b1, 8'd127});
        send_tick('{1'b0, 1'b1, 1'b0, 8'd128});
        send_tick('{1'b0, 1'b1, 1'b1, 8'd255});
        send_tick('{1'b0, 1'b0, 1'b0, 8'h55});
        send_tick('{1'b0, 1'b1, 1'b1, 8'hAA});
        wait_drained();
    endtask

    task automatic test_press_kinds();
        set_controls(4'd1, 16'd2);
        // short press steps the colour
        offer(1'b1, 1'b0);
        offer(1'b0, 1'b1);
        // long press blanks, then the release restores
        offer(1'b1, 1'b0);
        repeat (3) offer(1'b0, 1'b0);
        offer(1'b0, 1'b1);
        offer(1'b1, 1'b0);
        offer(1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_zero_limits();
        set_controls(4'd0, 16'd0);
        // press taken without an agreeing tick, release counts as long
        offer(1'b1, 1'b1);
        offer(1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_limit_lowered();
        set_controls(4'd1, 16'd10);
        offer(1'b1, 1'b0);
        repeat (5) offer(1'b0, 1'b0);
        wait_drained();
        // hold already past the new limit: release is short
        set_controls(4'd1, 16'd3);
        offer(1'b0, 1'b1);
        wait_drained();
        set_controls(4'd1, 16'd10);
        offer(1'b1, 1'b0);
        repeat (3) offer(1'b0, 1'b0);
        wait_drained();
        // hold equals the new limit exactly: release is long
        set_controls(4'd1, 16'd3);
        offer(1'b0, 1'b0);
        offer(1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off_requests++;
        src_quiet = 1'b1;
        repeat (40) offer($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        src_quiet = 1'b0;
        wait_drained();
    endtask

    task automatic run_gestures(input int n);
        int start;
        int press_len;
        int rel_len;
        start = random_sent;
        while (random_sent - start < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    offer($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
            end
            else
            begin
                offer(1'b1, 1'b0);
                if ($urandom_range(0, 1) == 1)
                    press_len = int'(db_limit) + int'(lp_limit) +
                                int'($urandom_range(0, 6));
                else
                    press_len = int'($urandom_range(1, int'(db_limit) + int'(lp_limit) + 1));
                if (press_len > int'(db_limit) + 60)
                    press_len = int'(db_limit) + 60;
                // mostly held low with an occasional bounce
                repeat (press_len)
                    offer($urandom_range(0, 19) == 0, $urandom_range(0, 7) == 0);
                rel_len = int'($urandom_range(1, int'(db_limit) + 4));
                repeat (rel_len) offer(1'b0, $urandom_range(0, 7) != 0);
            end
        end
    endtask

    task automatic test_random_gestures();
        int db_set[9];
        int lp_set[9];
        db_set = '{15, 1, 3, 0, 7, 15, 2, 1, 5};
        lp_set = '{65535, 1, 12, 5, 30, 0, 3, 20, 8};
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph >= 7)
            begin
                db_set[ph] = int'($urandom_range(1, 15));
                lp_set[ph] = int'($urandom_range(1, 40));
            end
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            set_controls(bcsld_pkg::DEBOUNCE_W'(db_set[ph]), bcsld_pkg::HOLD_W'(lp_set[ph]));
            run_gestures(210);
            wait_drained();
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_served != hold_off_requests)
            begin
                hold_off_served++;
                wait_left = HOLD_OFF_CYCLES;
            end
            else if (wait_left == 0 && !sink_quiet)
            begin
                wait_left = pick_gap();
            end
            if (wait_left > 0)
            begin
                result_ch.ready <= 1'b0;
                wait_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        lamp_result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (lamp_results_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, color %0d", $time,
                         result_ch.current_color);
                fail_count++;
            end
            else
            begin
                want = lamp_results_due.pop_front();
                check_field("duty_red_a", 16'(want.duty.red_a),
                            16'(result_ch.duty_red_a));
                check_field("duty_green_a", 16'(want.duty.green_a),
                            16'(result_ch.duty_green_a));
                check_field("duty_blue_a", 16'(want.duty.blue_a),
                            16'(result_ch.duty_blue_a));
                check_field("duty_red_b", 16'(want.duty.red_b),
                            16'(result_ch.duty_red_b));
                check_field("duty_green_b", 16'(want.duty.green_b),
                            16'(result_ch.duty_green_b));
                check_field("duty_blue_b", 16'(want.duty.blue_b),
                            16'(result_ch.duty_blue_b));
                check_field("current_color", 16'(want.color),
                            16'(result_ch.current_color));
                check_field("lights_blanked", 16'(want.blanked),
                            16'(result_ch.lights_blanked));
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = bcsld_pkg::REG_DEBOUNCE_LIMIT;
        cfg_data             = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.button_arm   = 1'b0;
        tick_ch.button_pin   = 1'b1;
        tick_ch.led_signal   = 1'b0;
        tick_ch.source_level = '0;
        result_ch.ready      = 1'b0;
        fail_count           = 0;
        cycle_count          = 0;
        random_sent          = 0;
        hold_off_requests    = 0;
        hold_off_served      = 0;
        src_quiet            = 1'b0;
        sink_quiet           = 1'b0;
        reset_selector();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_outputs();
        test_press_kinds();
        test_zero_limits();
        test_limit_lowered();
        set_controls(4'd2, 16'd6);
        test_backpressure();
        test_random_gestures();
        wait_drained();

        if (fail_count == 0 && lamp_results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
